### sv/plf_pkg.sv
package plf_pkg;

   localparam int PKT_LEN_W = 20;
   localparam int FBL_W = 17;
   localparam int CAP_W = 16;
   localparam int POS_W = 4;
   localparam int TMPL_SLOTS = 16;

   localparam logic [CAP_W-1:0] LEN_NONE = 16'hFFFF;
   localparam logic [CAP_W-1:0] LEN_NEG_MIN = 16'h8000;

   typedef enum logic [2:0] {
      FT_NONE  = 3'd0,
      FT_ONE   = 3'd1,
      FT_TWO   = 3'd2,
      FT_FOUR  = 3'd3,
      FT_EIGHT = 3'd4,
      FT_STR   = 3'd5,
      FT_ARR   = 3'd6,
      FT_SLOT  = 3'd7
   } field_kind_type;

   typedef enum logic [3:0] {
      PH_PLAIN   = 4'b0001,
      PH_PREFIX  = 4'b0010,
      PH_SLOTMID = 4'b0100,
      PH_METALEN = 4'b1000
   } slot_phase_type;

   typedef enum logic [1:0] {
      ST_INSIDE  = 2'd0,
      ST_LAST    = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_BADSLOT = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]                   len;
      field_kind_type [TMPL_SLOTS-1:0]    fields;
   } template_type;

   typedef struct packed {
      status_type             status;
      logic [PKT_LEN_W-1:0]   length;
      logic [7:0]             opcode;
   } result_type;

   // Field layout of every known opcode. Position 0 is the opcode byte itself.
   function automatic template_type template_rom(input logic [7:0] op);
      template_type t;
      for (int k = 0; k < TMPL_SLOTS; k++) begin
         t.fields[k] = FT_NONE;
      end
      t.len = '0;
      t.fields[0] = FT_ONE;
      case (op)
         8'h00: begin
            t.len = 4'd2; t.fields[1] = FT_FOUR;
         end
         8'h02: begin
            t.len = 4'd5; t.fields[1] = FT_ONE; t.fields[2] = FT_STR;
            t.fields[3] = FT_STR; t.fields[4] = FT_FOUR;
         end
         8'h03, 8'hCB, 8'hFF: begin
            t.len = 4'd2; t.fields[1] = FT_STR;
         end
         8'h07: begin
            t.len = 4'd4; t.fields[1] = FT_FOUR; t.fields[2] = FT_FOUR;
            t.fields[3] = FT_ONE;
         end
         8'h0A, 8'h65, 8'hCD: begin
            t.len = 4'd2; t.fields[1] = FT_ONE;
         end
         8'h0B: begin
            t.len = 4'd6; t.fields[1] = FT_EIGHT; t.fields[2] = FT_EIGHT;
            t.fields[3] = FT_EIGHT; t.fields[4] = FT_EIGHT; t.fields[5] = FT_ONE;
         end
         8'h0C: begin
            t.len = 4'd4; t.fields[1] = FT_FOUR; t.fields[2] = FT_FOUR;
            t.fields[3] = FT_ONE;
         end
         8'h0D: begin
            t.len = 4'd8; t.fields[1] = FT_EIGHT; t.fields[2] = FT_EIGHT;
            t.fields[3] = FT_EIGHT; t.fields[4] = FT_EIGHT; t.fields[5] = FT_FOUR;
            t.fields[6] = FT_FOUR; t.fields[7] = FT_ONE;
         end
         8'h0E: begin
            t.len = 4'd6; t.fields[1] = FT_ONE; t.fields[2] = FT_FOUR;
            t.fields[3] = FT_ONE; t.fields[4] = FT_FOUR; t.fields[5] = FT_ONE;
         end
         8'h0F: begin
            t.len = 4'd9; t.fields[1] = FT_FOUR; t.fields[2] = FT_ONE;
            t.fields[3] = FT_FOUR; t.fields[4] = FT_ONE; t.fields[5] = FT_SLOT;
            t.fields[6] = FT_ONE; t.fields[7] = FT_ONE; t.fields[8] = FT_ONE;
         end
         8'h10: begin
            t.len = 4'd2; t.fields[1] = FT_TWO;
         end
         8'h12, 8'h13: begin
            t.len = 4'd3; t.fields[1] = FT_FOUR; t.fields[2] = FT_ONE;
         end
         8'h66: begin
            t.len = 4'd7; t.fields[1] = FT_ONE; t.fields[2] = FT_TWO;
            t.fields[3] = FT_ONE; t.fields[4] = FT_TWO; t.fields[5] = FT_ONE;
            t.fields[6] = FT_SLOT;
         end
         8'h6A: begin
            t.len = 4'd4; t.fields[1] = FT_ONE; t.fields[2] = FT_TWO;
            t.fields[3] = FT_ONE;
         end
         8'h6B: begin
            t.len = 4'd3; t.fields[1] = FT_TWO; t.fields[2] = FT_SLOT;
         end
         8'h6C: begin
            t.len = 4'd3; t.fields[1] = FT_ONE; t.fields[2] = FT_ONE;
         end
         8'h82: begin
            t.len = 4'd8; t.fields[1] = FT_FOUR; t.fields[2] = FT_TWO;
            t.fields[3] = FT_FOUR; t.fields[4] = FT_STR; t.fields[5] = FT_STR;
            t.fields[6] = FT_STR; t.fields[7] = FT_STR;
         end
         8'hCA: begin
            t.len = 4'd4; t.fields[1] = FT_ONE; t.fields[2] = FT_ONE;
            t.fields[3] = FT_ONE;
         end
         8'hCC: begin
            t.len = 4'd5; t.fields[1] = FT_STR; t.fields[2] = FT_ONE;
            t.fields[3] = FT_ONE; t.fields[4] = FT_ONE;
         end
         8'hFA: begin
            t.len = 4'd3; t.fields[1] = FT_STR; t.fields[2] = FT_ARR;
         end
         8'hFE: begin
            t.len = 4'd1;
         end
         default: begin
            t.len = '0;
            t.fields[0] = FT_NONE;
         end
      endcase
      return t;
   endfunction

endpackage

### sv/plf_byte_reg.sv
module plf_byte_reg
   import plf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   output logic         byte_valid,
   output logic [7:0]   byte_data,
   input  logic         byte_take
);

   logic         valid_ff;
   logic         valid_in;
   logic [7:0]   data_ff;
   logic         accept;

   assign req_ready = !valid_ff || byte_take;
   assign accept = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (byte_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data = data_ff;

endmodule

### sv/plf_frame_tracker.sv
module plf_frame_tracker
   import plf_pkg::*;
#(
   parameter int LENGTH_BITS = 20
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic [7:0]   rx_byte,
   output result_type   result
);

   logic                    in_packet_ff, in_packet_in;
   logic [7:0]              opcode_ff, opcode_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [FBL_W-1:0]        fbl_ff, fbl_in;
   slot_phase_type          phase_ff, phase_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in;

   template_type            tmpl;
   logic [POS_W-1:0]        nf_pos;
   logic                    nf_done;
   field_kind_type          nf_kind;
   slot_phase_type          nf_phase;
   logic [FBL_W-1:0]        nf_fbl;
   field_kind_type          cur_kind;
   logic [CAP_W-1:0]        cap_w;
   logic [FBL_W-1:0]        fbl_w;
   logic [LENGTH_BITS-1:0]  count_w;
   logic                    field_done;
   logic                    bad;
   logic                    to_idle;
   status_type              status;

   always_comb begin
      tmpl = template_rom(in_packet_ff ? opcode_ff : rx_byte);
      nf_pos = (in_packet_ff ? pos_ff : '0) + POS_W'(1);
      nf_done = nf_pos >= tmpl.len;
      nf_kind = tmpl.fields[nf_pos];
      cur_kind = tmpl.fields[pos_ff];

      case (nf_kind)
         FT_STR, FT_ARR, FT_SLOT: begin
            nf_phase = PH_PREFIX; nf_fbl = FBL_W'(2);
         end
         FT_TWO: begin
            nf_phase = PH_PLAIN; nf_fbl = FBL_W'(2);
         end
         FT_FOUR: begin
            nf_phase = PH_PLAIN; nf_fbl = FBL_W'(4);
         end
         FT_EIGHT: begin
            nf_phase = PH_PLAIN; nf_fbl = FBL_W'(8);
         end
         default: begin
            nf_phase = PH_PLAIN; nf_fbl = FBL_W'(1);
         end
      endcase

      in_packet_in = in_packet_ff;
      opcode_in = opcode_ff;
      pos_in = pos_ff;
      phase_in = phase_ff;
      cap_w = cap_ff;
      fbl_w = fbl_ff;
      field_done = 1'b0;
      bad = 1'b0;
      to_idle = 1'b0;
      status = ST_INSIDE;

      if (!in_packet_ff) begin
         opcode_in = rx_byte;
         count_w = LENGTH_BITS'(1);
         if (tmpl.len == '0) begin
            status = ST_UNKNOWN;
            to_idle = 1'b1;
         end else begin
            in_packet_in = 1'b1;
            field_done = 1'b1;
         end
      end else begin
         count_w = count_ff + LENGTH_BITS'(1);
         if (phase_ff == PH_PREFIX || phase_ff == PH_METALEN) begin
            cap_w = {cap_ff[7:0], rx_byte};
         end
         if (fbl_ff != '0) begin
            fbl_w = fbl_ff - FBL_W'(1);
         end
      end

      cap_in = cap_w;
      fbl_in = fbl_w;

      if (in_packet_ff && fbl_w == '0) begin
         case (phase_ff)
            PH_PLAIN: begin
               field_done = 1'b1;
            end
            PH_PREFIX: begin
               if (cur_kind == FT_SLOT) begin
                  if (cap_w == LEN_NONE) begin
                     field_done = 1'b1;
                  end else if (cap_w == '0) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_SLOTMID;
                     fbl_in = FBL_W'(3);
                  end
               end else begin
                  if (cap_w == '0) begin
                     field_done = 1'b1;
                  end else begin
                     phase_in = PH_PLAIN;
                     fbl_in = (cur_kind == FT_STR) ? {cap_w, 1'b0} : {1'b0, cap_w};
                  end
               end
            end
            PH_SLOTMID: begin
               phase_in = PH_METALEN;
               fbl_in = FBL_W'(2);
               cap_in = '0;
            end
            PH_METALEN: begin
               if (cap_w == LEN_NONE) begin
                  field_done = 1'b1;
               end else if (cap_w == '0 || cap_w >= LEN_NEG_MIN) begin
                  bad = 1'b1;
               end else begin
                  phase_in = PH_PLAIN;
                  fbl_in = {1'b0, cap_w};
               end
            end
            default: begin
               phase_in = PH_PLAIN;
            end
         endcase
      end

      if (bad) begin
         status = ST_BADSLOT;
         to_idle = 1'b1;
      end else if (field_done) begin
         if (nf_done) begin
            status = ST_LAST;
            to_idle = 1'b1;
         end else begin
            pos_in = nf_pos;
            phase_in = nf_phase;
            fbl_in = nf_fbl;
            cap_in = '0;
         end
      end

      count_in = count_w;
      if (to_idle) begin
         in_packet_in = 1'b0;
         pos_in = '0;
         fbl_in = '0;
         phase_in = PH_PLAIN;
         cap_in = '0;
         count_in = '0;
      end

      result.status = status;
      result.length = PKT_LEN_W'(count_w);
      result.opcode = opcode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         opcode_ff <= '0;
         pos_ff <= '0;
         fbl_ff <= '0;
         phase_ff <= PH_PLAIN;
         cap_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         in_packet_ff <= in_packet_in;
         opcode_ff <= opcode_in;
         pos_ff <= pos_in;
         fbl_ff <= fbl_in;
         phase_ff <= phase_in;
         cap_ff <= cap_in;
         count_ff <= count_in;
      end
   end

   // Between packets the field tracking must be fully cleared.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> (phase_ff == PH_PLAIN && count_ff == '0 && pos_ff == '0))
      else $error("idle state not cleared");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("slot phase not one-hot");

   a_pos_in_template: assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> (pos_ff != '0 && pos_ff < tmpl.len))
      else $error("template position outside template");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && status != ST_INSIDE) |=> !in_packet_ff)
      else $error("packet end did not return to idle");

endmodule

### sv/packet_length_framer.sv
// Packet framer for a received byte stream. Each accepted item is one byte
// on req_rx_byte, and each byte produces exactly one result item: rsp_status
// is 0 inside a packet, 1 on the last byte of a packet (rsp_packet_length
// then holds the packet's total length), 2 for an opcode with no known
// layout, and 3 for an invalid slot id or metadata length; on codes 1 to 3
// the framer is idle again and the next byte is taken as an opcode.
// rsp_packet_opcode carries the opcode of the current packet. The framer
// sustains one byte per clock cycle while rsp_ready is high: an input
// register feeds combinational template lookup and counter update that
// loads the result register, so each byte passes through the input
// register and then the result register. While a result waits for
// rsp_ready, the input register holds its byte and a new byte is taken
// only while that register is empty or its byte is passed on. The byte
// count wraps at 2**LENGTH_BITS.
module packet_length_framer
   import plf_pkg::*;
#(
   parameter int LENGTH_BITS = 20
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [PKT_LEN_W-1:0]   rsp_packet_length,
   output logic [7:0]             rsp_packet_opcode
);

   logic         byte_valid;
   logic [7:0]   byte_data;
   logic         advance;
   result_type   result;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff;

   assign advance = byte_valid && (!rsp_valid_ff || rsp_ready);

   plf_byte_reg u_byte_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .byte_take   (advance)
   );

   plf_frame_tracker #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (byte_data),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_data_ff.status;
   assign rsp_packet_length = rsp_data_ff.length;
   assign rsp_packet_opcode = rsp_data_ff.opcode;

endmodule

### bench/packet_length_framer_test.sv
`timescale 1ns / 100ps

module packet_length_framer_test;
   import plf_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [PKT_LEN_W-1:0] rsp_packet_length;
   logic [7:0]           rsp_packet_opcode;

   packet_length_framer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_packet_length (rsp_packet_length),
      .rsp_packet_opcode (rsp_packet_opcode)
   );

   logic [7:0] known_ops [26] = '{
      8'h00, 8'h02, 8'h03, 8'h07, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
      8'h10, 8'h12, 8'h13, 8'h65, 8'h66, 8'h6A, 8'h6B, 8'h6C, 8'h82, 8'hCA,
      8'hCB, 8'hCC, 8'hCD, 8'hFA, 8'hFE, 8'hFF
   };
   logic [7:0] slot_ops [3] = '{8'h0F, 8'h66, 8'h6B};

   // Framer state as predicted from the accepted bytes.
   bit                   p_in_packet = 1'b0;
   logic [7:0]           p_opcode = 8'h00;
   logic [POS_W-1:0]     p_pos = '0;
   logic [FBL_W-1:0]     p_left = '0;
   slot_phase_type       p_phase = PH_PLAIN;
   logic [CAP_W-1:0]     p_cap = '0;
   logic [PKT_LEN_W-1:0] p_count = '0;

   result_type framing_q [$];
   logic [7:0] pkt_bytes [$];
   int         failures = 0;
   int         items_sent = 0;
   bit         gaps_on = 1'b0;
   int         stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic string layout_of(input logic [7:0] op);
      case (op)
         8'h00: return "oi";
         8'h02: return "obzzi";
         8'h03, 8'hCB, 8'hFF: return "oz";
         8'h07: return "oii?";
         8'h0A: return "o?";
         8'h0B: return "odddd?";
         8'h0C: return "off?";
         8'h0D: return "oddddff?";
         8'h0E: return "obibib";
         8'h0F: return "oibibqbbb";
         8'h10: return "os";
         8'h12, 8'h13: return "oib";
         8'h65, 8'hCD: return "ob";
         8'h66: return "obs?s?q";
         8'h6A: return "obs?";
         8'h6B: return "osq";
         8'h6C: return "obb";
         8'h82: return "oisizzzz";
         8'hCA: return "obbb";
         8'hCC: return "ozbbb";
         8'hFA: return "oza";
         8'hFE: return "o";
         default: return "";
      endcase
   endfunction

   function automatic byte unsigned field_at(input logic [7:0] op, input logic [3:0] pos);
      string s;
      s = layout_of(op);
      if (pos >= s.len()) return 8'h00;
      return s[pos];
   endfunction

   function automatic void return_to_idle();
      p_in_packet = 1'b0;
      p_pos = '0;
      p_left = '0;
      p_phase = PH_PLAIN;
      p_cap = '0;
      p_count = '0;
   endfunction

   // Steps to the next field and reports whether the packet is complete.
   function automatic bit advance_field();
      byte unsigned c;
      p_pos = p_pos + 1'b1;
      if (p_pos >= layout_of(p_opcode).len()) return 1'b1;
      c = field_at(p_opcode, p_pos);
      p_cap = '0;
      p_phase = PH_PLAIN;
      case (c)
         "z", "a", "q": begin
            p_phase = PH_PREFIX;
            p_left = 17'd2;
         end
         "s": p_left = 17'd2;
         "i", "f": p_left = 17'd4;
         "d", "l": p_left = 17'd8;
         default: p_left = 17'd1;
      endcase
      return 1'b0;
   endfunction

   function automatic result_type frame_byte(input logic [7:0] b);
      result_type r;
      logic [CAP_W-1:0] l;
      byte unsigned c;
      int n;
      bit done;
      bit bad;
      r.status = ST_INSIDE;
      done = 1'b0;
      bad = 1'b0;
      if (!p_in_packet) begin
         p_opcode = b;
         p_count = PKT_LEN_W'(1);
         r.length = p_count;
         if (layout_of(b).len() == 0) begin
            r.status = ST_UNKNOWN;
            return_to_idle();
         end else begin
            p_in_packet = 1'b1;
            p_pos = '0;
            if (advance_field()) begin
               r.status = ST_LAST;
               return_to_idle();
            end
         end
      end else begin
         p_count = p_count + 1'b1;
         r.length = p_count;
         if (p_phase == PH_PREFIX || p_phase == PH_METALEN) p_cap = {p_cap[7:0], b};
         if (p_left > 0) p_left = p_left - 1'b1;
         if (p_left == 0) begin
            l = p_cap;
            case (p_phase)
               PH_PLAIN: done = 1'b1;
               PH_PREFIX: begin
                  c = field_at(p_opcode, p_pos);
                  if (c == "q") begin
                     if (l == LEN_NONE) done = 1'b1;
                     else if (l == 0) bad = 1'b1;
                     else begin
                        p_phase = PH_SLOTMID;
                        p_left = 17'd3;
                     end
                  end else begin
                     n = (c == "z") ? 2 * int'(l) : int'(l);
                     if (n == 0) done = 1'b1;
                     else begin
                        p_phase = PH_PLAIN;
                        p_left = 17'(n);
                     end
                  end
               end
               PH_SLOTMID: begin
                  p_phase = PH_METALEN;
                  p_left = 17'd2;
                  p_cap = '0;
               end
               default: begin
                  if (l == LEN_NONE) done = 1'b1;
                  else if (l == 0 || l >= LEN_NEG_MIN) bad = 1'b1;
                  else begin
                     p_phase = PH_PLAIN;
                     p_left = 17'(l);
                  end
               end
            endcase
            if (bad) begin
               r.status = ST_BADSLOT;
               return_to_idle();
            end else if (done && advance_field()) begin
               r.status = ST_LAST;
               return_to_idle();
            end
         end
      end
      r.opcode = p_opcode;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) framing_q.push_back(frame_byte(req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (framing_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected item, status %0d length %0d opcode %0h",
                        $time, rsp_status, rsp_packet_length, rsp_packet_opcode);
            end else begin
               want = framing_q.pop_front();
               if (rsp_status !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_packet_length !== want.length) begin
                  failures++;
                  $display("%0t: packet_length expected %0d, actual %0d",
                           $time, want.length, rsp_packet_length);
               end
               if (rsp_packet_opcode !== want.opcode) begin
                  failures++;
                  $display("%0t: packet_opcode expected %0h, actual %0h",
                           $time, want.opcode, rsp_packet_opcode);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Called and returning at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[k]) send_byte(pkt_bytes[k]);
   endtask

   // Feeds filler until the framer is idle again; length prefixes are kept small.
   task automatic finish_open_packet();
      logic [7:0] b;
      while (p_in_packet) begin
         if (p_phase == PH_PREFIX || p_phase == PH_METALEN)
            b = (p_left == 17'd2) ? 8'h00 : 8'($urandom_range(0, 3));
         else b = 8'($urandom_range(0, 255));
         send_byte(b);
      end
   endtask

   function automatic logic [15:0] pick_length();
      int pick;
      pick = $urandom_range(0, 31);
      if (pick < 5) return 16'($urandom_range(4, 40));
      return 16'($urandom_range(0, 3));
   endfunction

   function automatic void push_random(input int count);
      repeat (count) pkt_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Builds one packet for an opcode; a spoiled one carries a bad slot or is cut short.
   function automatic void compose_packet(input logic [7:0] op, input bit spoil);
      string lay;
      logic [15:0] l;
      logic [15:0] id;
      bit bad_id;
      bit has_slot;
      int keep;
      lay = layout_of(op);
      pkt_bytes.delete();
      bad_id = spoil && $urandom_range(0, 1);
      has_slot = 1'b0;
      for (int k = 0; k < lay.len(); k++) begin
         case (lay[k])
            "o": pkt_bytes.push_back(op);
            "s": push_random(2);
            "i", "f": push_random(4);
            "d", "l": push_random(8);
            "z", "a": begin
               l = pick_length();
               pkt_bytes.push_back(l[15:8]);
               pkt_bytes.push_back(l[7:0]);
               push_random((lay[k] == "z") ? 2 * int'(l) : int'(l));
            end
            "q": begin
               has_slot = 1'b1;
               if (bad_id) id = 16'h0000;
               else if (!spoil && $urandom_range(0, 3) == 0) id = LEN_NONE;
               else id = 16'($urandom_range(1, 16'hFFFE));
               pkt_bytes.push_back(id[15:8]);
               pkt_bytes.push_back(id[7:0]);
               if (id != LEN_NONE && id != 0) begin
                  push_random(3);
                  if (spoil) begin
                     if ($urandom_range(0, 1)) l = 16'h0000;
                     else l = 16'($urandom_range(16'h8000, 16'hFFFE));
                  end else if ($urandom_range(0, 3) == 0) begin
                     l = LEN_NONE;
                  end else begin
                     l = 16'($urandom_range(1, 5));
                  end
                  pkt_bytes.push_back(l[15:8]);
                  pkt_bytes.push_back(l[7:0]);
                  if (l != LEN_NONE && !spoil) push_random(int'(l));
               end
            end
            default: push_random(1);
         endcase
      end
      if (spoil && !has_slot && pkt_bytes.size() > 1) begin
         keep = $urandom_range(1, pkt_bytes.size() - 1);
         pkt_bytes = pkt_bytes[0:keep-1];
      end
   endfunction

   task automatic test_unknown_opcodes();
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'hFD);
      send_byte(8'h7F);
   endtask

   task automatic test_opcode_only();
      send_byte(8'hFE);
      send_byte(8'hFE);
   endtask

   task automatic test_zero_lengths();
      pkt_bytes = '{8'hFA, 8'h00, 8'h00, 8'h00, 8'h00};
      send_packet();
      pkt_bytes = '{8'hFF, 8'h00, 8'h00};
      send_packet();
   endtask

   task automatic test_slot_cases();
      pkt_bytes = '{8'h6B, 8'hAA, 8'h55, 8'h00, 8'h00};
      send_packet();
      pkt_bytes = '{8'h6B, 8'h00, 8'hFF, 8'hFF, 8'hFF};
      send_packet();
      pkt_bytes = '{8'h6B, 8'h01, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h00, 8'h00};
      send_packet();
      pkt_bytes = '{8'h6B, 8'h01, 8'h02, 8'hFF, 8'hFE, 8'h01, 8'h02, 8'h03, 8'h80, 8'h00};
      send_packet();
      pkt_bytes = '{8'h6B, 8'h01, 8'h02, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hFE};
      send_packet();
      pkt_bytes = '{8'h6B, 8'h01, 8'h02, 8'h00, 8'h01, 8'hC3, 8'h3C, 8'h0F, 8'hFF, 8'hFF};
      send_packet();
   endtask

   task automatic test_long_fields();
      gaps_on = 1'b0;
      pkt_bytes = '{8'hFA, 8'h00, 8'h28};
      push_random(80);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h40);
      push_random(64);
      send_packet();
   endtask

   task automatic test_random_stream();
      int stop;
      int k;
      int pick;
      logic [7:0] op;
      gaps_on = 1'b1;
      stop = 550;
      k = 0;
      while (items_sent < stop) begin
         if (items_sent > stop - 150) gaps_on = 1'b0;
         pick = $urandom_range(0, 19);
         if (k < 26 || pick < 14) begin
            op = (k < 26) ? known_ops[k] : known_ops[$urandom_range(0, 25)];
            compose_packet(op, 1'b0);
            send_packet();
         end else if (pick < 17) begin
            if ($urandom_range(0, 1)) op = slot_ops[$urandom_range(0, 2)];
            else op = known_ops[$urandom_range(0, 25)];
            compose_packet(op, 1'b1);
            send_packet();
            finish_open_packet();
         end else begin
            send_byte(8'($urandom_range(0, 255)));
            finish_open_packet();
         end
         k++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      gaps_on = 1'b1;
      test_unknown_opcodes();
      test_opcode_only();
      test_zero_lengths();
      test_slot_cases();
      test_long_fields();
      test_random_stream();
      req_valid <= 1'b0;
      gaps_on = 1'b0;
      while (framing_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
